// ===== rtl/core/abs_pkg.sv =====
`default_nettype none
package abs_pkg;

  // width of the low battery reminder counter
  localparam int ReminderBits = 22;
  localparam int IntervalBits = 22;
  localparam int ReminderCmpBits = (ReminderBits > IntervalBits) ? ReminderBits : IntervalBits;

  localparam int ToggleBits = 12;
  localparam int TimerBits  = 10;

  localparam logic signed [ToggleBits-1:0] ToggleMax        = 12'sd2047;
  localparam logic signed [ToggleBits-1:0] FaultOnMs        = 12'sd300;
  localparam logic signed [ToggleBits-1:0] FaultOffMs       = 12'sd2000;
  localparam logic signed [ToggleBits-1:0] EstrusToggleMs   = 12'sd200;
  localparam logic signed [ToggleBits-1:0] EstrusPauseStart = -12'sd800;

  localparam logic [1:0] EstrusLastToggle = 2'd3;

  localparam logic [IntervalBits-1:0] IntervalRst = 22'd1800000;

  // operation request codes
  localparam logic [1:0] OpNone = 2'd0;

  // configuration register indexes
  localparam logic [1:0] CfgAlarmEnable  = 2'd0;
  localparam logic [1:0] CfgStopAfterAck = 2'd1;
  localparam logic [1:0] CfgInterval     = 2'd2;

  typedef enum logic [2:0] {
    PatNone        = 3'd0,
    PatDoubleClick = 3'd1,
    PatLongPress   = 3'd2,
    PatStopConfirm = 3'd3,
    PatLowBattery  = 3'd4
  } pat_t;

  typedef struct packed {
    logic       estrus_detected;
    logic       card_ok;
    logic       clock_ok;
    logic       power_monitor_ok;
    logic       sensor_one_dirty;
    logic       sensor_two_dirty;
    logic       battery_low;
    logic       ack_pulse;
    logic [1:0] operation;
  } in_item_t;

  typedef struct packed {
    logic buzzer_drive;
    logic alarm_active;
    logic fault_alarm;
    logic estrus_alarm;
  } out_item_t;

  typedef struct packed {
    logic                    alarm_enable;
    logic                    stop_after_ack;
    logic [IntervalBits-1:0] low_battery_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic start;
    pat_t pat;
  } pat_cmd_t;

  // segment length in ms, segments alternate on and off
  function automatic logic [TimerBits-1:0] seg_len(pat_t p, logic [2:0] step);
    logic [TimerBits-1:0] len;
    len = '0;
    case (p)
      PatDoubleClick: len = 10'd80;
      PatLongPress:   len = (step == 3'd2) ? 10'd160 : 10'd80;
      PatStopConfirm: len = (step == 3'd0) ? 10'd100 : 10'd0;
      PatLowBattery:  len = 10'd500;
      default:        len = '0;
    endcase
    return len;
  endfunction

  function automatic logic [1:0] seg_num(pat_t p);
    logic [1:0] n;
    n = 2'd0;
    case (p)
      PatDoubleClick: n = 2'd3;
      PatLongPress:   n = 2'd3;
      PatStopConfirm: n = 2'd1;
      PatLowBattery:  n = 2'd3;
      default:        n = 2'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/abs_pattern.sv =====
`default_nettype none
module abs_pattern (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire abs_pkg::pat_cmd_t cmd,
  output logic                 busy,
  output logic                 drive
);

  abs_pkg::pat_t                  play_r, play_nxt, cur_pat;
  logic [2:0]                     step_r, step_nxt, cur_step;
  logic [abs_pkg::TimerBits-1:0]  timer_r, timer_nxt, cur_timer, timer_inc;
  logic [2:0]                     step_inc;

  assign busy = (play_r != abs_pkg::PatNone);

  always_comb begin
    cur_pat   = cmd.start ? cmd.pat : play_r;
    cur_step  = cmd.start ? 3'd0 : step_r;
    cur_timer = cmd.start ? '0 : timer_r;
    timer_inc = cur_timer + abs_pkg::TimerBits'(1);
    step_inc  = cur_step + 3'd1;
    play_nxt  = cur_pat;
    step_nxt  = cur_step;
    timer_nxt = timer_inc;
    drive     = 1'b0;
    if (cur_step >= {1'b0, abs_pkg::seg_num(cur_pat)}) begin
      // unknown pattern or past its end
      play_nxt  = abs_pkg::PatNone;
      step_nxt  = 3'd0;
      timer_nxt = '0;
    end else begin
      drive = ~cur_step[0];
      if (timer_inc >= abs_pkg::seg_len(cur_pat, cur_step)) begin
        timer_nxt = '0;
        step_nxt  = step_inc;
        if (step_inc >= {1'b0, abs_pkg::seg_num(cur_pat)}) begin
          play_nxt = abs_pkg::PatNone;
          step_nxt = 3'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      play_r  <= abs_pkg::PatNone;
      step_r  <= 3'd0;
      timer_r <= '0;
    end else if (en && (busy || cmd.start)) begin
      play_r  <= play_nxt;
      step_r  <= step_nxt;
      timer_r <= timer_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/abs_alarm.sv =====
`default_nettype none
module abs_alarm (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire abs_pkg::cfg_t     cfg,
  input  wire abs_pkg::in_item_t item,
  output abs_pkg::out_item_t     res
);

  localparam int RemBits = abs_pkg::ReminderBits;
  localparam int CmpBits = abs_pkg::ReminderCmpBits;
  localparam int TogBits = abs_pkg::ToggleBits;

  logic                      fault_muted_r, fault_muted_nxt;
  logic                      estrus_acked_r, estrus_acked_nxt;
  logic                      fault_phase_r, fault_phase_nxt;
  logic                      estrus_phase_r, estrus_phase_nxt;
  logic [1:0]                toggle_cnt_r, toggle_cnt_nxt;
  logic signed [TogBits-1:0] tog_r, tog_nxt, tog, fault_thr;
  logic [RemBits-1:0]        rem_r, rem_nxt, rem;
  abs_pkg::pat_t             pending_r, pending_nxt, pend1, pend2;

  logic              fault, est_al, flt_al, batt_trig, busy, pat_drive, drive;
  abs_pkg::pat_cmd_t pat_cmd;

  abs_pattern u_pattern (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .cmd   (pat_cmd),
    .busy  (busy),
    .drive (pat_drive)
  );

  always_comb begin
    fault = !item.card_ok || !item.clock_ok || !item.power_monitor_ok ||
            item.sensor_one_dirty || item.sensor_two_dirty;
    // latches release when their cause clears, ack sets them
    fault_muted_nxt  = fault && (fault_muted_r || item.ack_pulse);
    estrus_acked_nxt = item.estrus_detected && (estrus_acked_r || item.ack_pulse);

    pend1 = pending_r;
    if (!busy) begin
      if (item.operation != abs_pkg::OpNone) begin
        pend1 = abs_pkg::pat_t'({1'b0, item.operation});
      end
      if (item.ack_pulse) begin
        pend1 = abs_pkg::PatStopConfirm;
      end
    end

    est_al = item.estrus_detected && cfg.alarm_enable &&
             (!estrus_acked_nxt || !cfg.stop_after_ack);
    flt_al = fault && cfg.alarm_enable && !fault_muted_nxt;

    tog = (tog_r != abs_pkg::ToggleMax) ? tog_r + TogBits'(1) : tog_r;
    rem = (rem_r != '1) ? rem_r + RemBits'(1) : rem_r;

    batt_trig = item.battery_low && !est_al && cfg.alarm_enable &&
                (CmpBits'(rem) >= CmpBits'(cfg.low_battery_interval_ms));
    pend2 = batt_trig ? abs_pkg::PatLowBattery : pend1;

    fault_thr = fault_phase_r ? abs_pkg::FaultOnMs : abs_pkg::FaultOffMs;

    fault_phase_nxt  = fault_phase_r;
    estrus_phase_nxt = estrus_phase_r;
    toggle_cnt_nxt   = toggle_cnt_r;
    tog_nxt          = tog;
    rem_nxt          = rem;
    pending_nxt      = pend1;
    pat_cmd.start    = 1'b0;
    pat_cmd.pat      = pend2;
    drive            = 1'b0;

    if (busy) begin
      drive = pat_drive;
    end else if (flt_al) begin
      if (tog > fault_thr) begin
        fault_phase_nxt = ~fault_phase_r;
        tog_nxt         = '0;
      end
      drive = fault_phase_nxt;
    end else begin
      if (batt_trig) begin
        rem_nxt = '0;
      end
      pending_nxt = abs_pkg::PatNone;
      if (pend2 != abs_pkg::PatNone) begin
        pat_cmd.start = 1'b1;
        drive         = pat_drive;
      end else if (est_al) begin
        if (tog > abs_pkg::EstrusToggleMs) begin
          estrus_phase_nxt = ~estrus_phase_r;
          if (toggle_cnt_r == abs_pkg::EstrusLastToggle) begin
            // pause after the double beep
            toggle_cnt_nxt = 2'd0;
            tog_nxt        = abs_pkg::EstrusPauseStart;
          end else begin
            toggle_cnt_nxt = toggle_cnt_r + 2'd1;
            tog_nxt        = '0;
          end
        end
        drive = estrus_phase_nxt;
      end else begin
        toggle_cnt_nxt = 2'd0;
      end
    end

    res.buzzer_drive = drive;
    res.alarm_active = est_al || flt_al;
    res.fault_alarm  = flt_al;
    res.estrus_alarm = est_al;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_muted_r  <= 1'b0;
      estrus_acked_r <= 1'b0;
      fault_phase_r  <= 1'b0;
      estrus_phase_r <= 1'b0;
      toggle_cnt_r   <= 2'd0;
      tog_r          <= '0;
      rem_r          <= '0;
      pending_r      <= abs_pkg::PatNone;
    end else if (en) begin
      fault_muted_r  <= fault_muted_nxt;
      estrus_acked_r <= estrus_acked_nxt;
      fault_phase_r  <= fault_phase_nxt;
      estrus_phase_r <= estrus_phase_nxt;
      toggle_cnt_r   <= toggle_cnt_nxt;
      tog_r          <= tog_nxt;
      rem_r          <= rem_nxt;
      pending_r      <= pending_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/alarm_buzzer_sequencer_top.sv =====
`default_nettype none
// channel   direction  handshake          payload
// in_       input      in_valid/in_stall  abs_pkg::in_item_t, one 1 ms tick
// out_      output     out_valid/out_stall abs_pkg::out_item_t, one per tick
// cfg_      input      cfg_valid/cfg_ready cfg_index, cfg_data (22 bit)
//
// one item per clock sustained while out_stall is low; items pass the input register then the result register
// all alarm, beep and pattern state updates in the single cycle an item leaves the input register
// synchronous active-low reset clears state and restores register defaults
// out_stall holds the result; the input register keeps its item and raises in_stall
// cfg writes are always taken (cfg_ready high)
module alarm_buzzer_sequencer_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire abs_pkg::in_item_t             in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output abs_pkg::out_item_t                 out_data,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [abs_pkg::IntervalBits-1:0] cfg_data
);

  abs_pkg::in_item_t  in_r;
  abs_pkg::out_item_t out_r, res;
  abs_pkg::cfg_t      cfg_r;
  logic               s1_valid_r, out_valid_r;
  logic               out_free, advance, accept;

  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = s1_valid_r && out_free;
  assign in_stall  = s1_valid_r && !out_free;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  abs_alarm u_alarm (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .cfg   (cfg_r),
    .item  (in_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.alarm_enable            <= 1'b1;
      cfg_r.stop_after_ack          <= 1'b1;
      cfg_r.low_battery_interval_ms <= abs_pkg::IntervalRst;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        abs_pkg::CfgAlarmEnable:  cfg_r.alarm_enable            <= cfg_data[0];
        abs_pkg::CfgStopAfterAck: cfg_r.stop_after_ack          <= cfg_data[0];
        abs_pkg::CfgInterval:     cfg_r.low_battery_interval_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  a_alarm_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.alarm_active == (out_r.fault_alarm || out_r.estrus_alarm)))
    else $error("alarm_active does not match the alarm flags");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |=> s1_valid_r)
    else $error("held item dropped from input register");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded after advance");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !advance)
    else $error("stalled result overwritten");

endmodule
`default_nettype wire
